### src/seven_bit_group_encoder_unit_defines.svh
// Assertion macros shared by the checker of the seven-bit group encoder.
`ifndef SEVEN_BIT_GROUP_ENCODER_UNIT_DEFINES_SVH
`define SEVEN_BIT_GROUP_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk and held off during reset.
`define SBGE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk and held off during reset.
`define SBGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/sbge_pkg.sv
// Types and constants shared by the seven-bit group encoder modules.
package sbge_pkg;

    localparam int GROUP_SIZE = 7;
    localparam int IDX_W      = 3;
    localparam int CODE_W     = 7;
    localparam int BYTE_W     = 8;

    // Position of the last byte of a full group.
    localparam logic [IDX_W-1:0] GROUP_LAST = IDX_W'(GROUP_SIZE - 1);
    // Output select code of the group header; codes above it pick held bytes.
    localparam logic [IDX_W-1:0] SEL_HEADER = '0;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_payload;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] coded_byte;
        logic              is_header;
        logic              last_of_run;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             store;
        logic             load;
        logic             clear;
        logic [IDX_W-1:0] sel;
        logic             last;
    } sbge_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             flush;
        logic [IDX_W-1:0] pos;
        logic             end_of_payload;
    } sbge_status_t;

endpackage

### src/seven_bit_group_encoder_unit.sv
// Top level of the seven-bit group encoder.
//
// Input channel (s_valid, s_ready, s_data): one payload byte per transfer,
// with end_of_payload marking the final byte. Output channel (m_valid,
// m_ready, m_data): coded bytes, each a group header or a data byte's low
// seven bits, with last_of_run on the final coded byte of the payload.
// Bytes are held in groups of seven. A byte that neither fills a group nor
// ends the payload is stored and produces nothing. A byte that fills the
// group or ends the payload starts a flush: the controller enters its emit
// state and then loads the header into the output register, followed by the
// group's bytes one per cycle while the receiver takes them, so a group of n
// bytes gives n + 1 coded bytes, and s_ready is low while they are sent. The
// rate is bounded by the single output register, one coded byte a cycle.
// When the receiver stalls, the output register holds its coded byte and the
// flush waits; s_ready stays low until the last byte of the group has been
// loaded into the output register.
// Reset (aresetn low at a clock edge) empties the group, clears the header
// bits and drops m_valid.
module seven_bit_group_encoder_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sbge_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sbge_pkg::out_item_t m_data
);
    import sbge_pkg::*;

    sbge_cmd_t    cmd;
    sbge_status_t status;

    sbge_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sbge_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

### src/sbge_datapath.sv
// Group storage, header bit collection and output register of the encoder.
module sbge_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sbge_pkg::in_item_t    s_data,
    input  sbge_pkg::sbge_cmd_t   cmd,
    output sbge_pkg::sbge_status_t status,
    output sbge_pkg::out_item_t   m_data
);
    import sbge_pkg::*;

    logic [CODE_W-1:0] group_reg [GROUP_SIZE];
    logic [CODE_W-1:0] top_bits_reg, top_bits_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    out_item_t         out_reg, out_next;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W-1:0]  byte_idx;
    logic              flush;

    // A count past the last position is treated as a full group.
    assign pos      = (count_reg >= GROUP_LAST) ? GROUP_LAST : count_reg;
    assign flush    = (pos == GROUP_LAST) || s_data.end_of_payload;
    assign byte_idx = cmd.sel - IDX_W'(1);

    assign status.flush          = flush;
    assign status.pos            = pos;
    assign status.end_of_payload = s_data.end_of_payload;

    always_comb begin
        top_bits_next = top_bits_reg;
        count_next    = count_reg;
        if (cmd.clear) begin
            top_bits_next = '0;
            count_next    = '0;
        end else if (cmd.store) begin
            top_bits_next = top_bits_reg
                          | (CODE_W'(s_data.data_byte[BYTE_W-1]) << pos);
            if (!flush) begin
                count_next = pos + IDX_W'(1);
            end
        end
    end

    always_comb begin
        out_next = out_reg;
        if (cmd.load) begin
            out_next.is_header   = (cmd.sel == SEL_HEADER);
            out_next.last_of_run = cmd.last;
            if (cmd.sel == SEL_HEADER) begin
                out_next.coded_byte = top_bits_reg;
            end else begin
                out_next.coded_byte = group_reg[byte_idx];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_bits_reg <= '0;
            count_reg    <= '0;
        end else begin
            top_bits_reg <= top_bits_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            group_reg[pos] <= s_data.data_byte[CODE_W-1:0];
        end
        out_reg <= out_next;
    end

    assign m_data = out_reg;

endmodule

### src/sbge_ctrl.sv
// Controller of the encoder: collects bytes, then walks a finished group out.
module sbge_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  sbge_pkg::sbge_status_t status,
    output sbge_pkg::sbge_cmd_t    cmd
);
    import sbge_pkg::*;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] total_reg, total_next;
    logic             end_reg, end_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept;
    logic             load;
    logic             at_last;

    assign s_ready = (state_reg == ST_COLLECT);
    assign accept  = s_valid && s_ready;
    // The output register takes the next coded byte when it is empty or
    // its content is being transferred in this cycle.
    assign load    = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign at_last = (idx_reg == total_reg);

    assign cmd.store = accept;
    assign cmd.load  = load;
    assign cmd.clear = load && at_last;
    assign cmd.sel   = idx_reg;
    assign cmd.last  = end_reg && at_last;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        total_next   = total_reg;
        end_next     = end_reg;
        m_valid_next = m_valid_reg;

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_COLLECT: begin
                if (accept && status.flush) begin
                    state_next = ST_EMIT;
                    idx_next   = SEL_HEADER;
                    total_next = status.pos + IDX_W'(1);
                    end_next   = status.end_of_payload;
                end
            end
            ST_EMIT: begin
                if (load) begin
                    if (at_last) begin
                        state_next = ST_COLLECT;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            idx_reg     <= '0;
            total_reg   <= '0;
            end_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            total_reg   <= total_next;
            end_reg     <= end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### src/sbge_checker.sv
// Port-level checker for the seven-bit group encoder, bound to the top level.
`include "seven_bit_group_encoder_unit_defines.svh"

module sbge_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input sbge_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input sbge_pkg::out_item_t m_data
);
    import sbge_pkg::*;

    // A stalled coded byte stays in place.
    `SBGE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled output changed")

    // While a header is on offer the group is still being sent out.
    `SBGE_ASSERT_NOW(a_hdr_busy, m_valid && m_data.is_header, !s_ready, "input taken during a flush")

    // A header transfer is followed at once by the group's first byte.
    `SBGE_ASSERT_NEXT(a_hdr_then_byte, m_valid && m_ready && m_data.is_header, m_valid && !m_data.is_header, "no data byte after header")

    // The final byte of a payload always starts a flush.
    `SBGE_ASSERT_NEXT(a_end_flush, s_valid && s_ready && s_data.end_of_payload, !s_ready, "end of payload did not flush")

endmodule

bind seven_bit_group_encoder_unit sbge_checker u_sbge_checker (.*);
